// ===== rtl/swm_pkg.sv =====
// ----------------------------------------------------------------------------
// swm_pkg
// Shared types, constants and helpers of the sliding window median filter.
// ----------------------------------------------------------------------------
`default_nettype none

package swm_pkg;

  localparam int unsigned WINDOW_MAX = 16;
  localparam int unsigned IDX_W      = $clog2(WINDOW_MAX);
  localparam int unsigned LEN_W      = 5;
  localparam int unsigned DATA_W     = 16;
  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(5);

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic [LEN_W-1:0]         len_t;

  // entry that travels around the ring of cells
  typedef struct packed {
    data_t val;
    idx_t  idx;
    logic  act;
  } swm_circ_t;

  typedef struct packed {
    logic load;
    logic step;
  } swm_cell_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RANK,
    ST_PICK,
    ST_DONE
  } swm_state_e;

  // zero acts as one, anything above the window depth saturates
  function automatic len_t swm_clamp_len(len_t len);
    len_t n;
    n = len;
    if (len == '0) begin
      n = LEN_W'(1);
    end else if (len > LEN_W'(WINDOW_MAX)) begin
      n = LEN_W'(WINDOW_MAX);
    end
    return n;
  endfunction

  // cell idx holds one of the newest n samples
  function automatic logic swm_active(idx_t idx, len_t n);
    logic [LEN_W:0] lim;
    lim = (LEN_W+1)'(WINDOW_MAX) - {1'b0, n};
    return ({{(LEN_W+1-IDX_W){1'b0}}, idx} >= lim);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/swm_if.sv =====
// ----------------------------------------------------------------------------
// swm_if
// Valid/ready request channels for samples in and medians out.
// ----------------------------------------------------------------------------
`default_nettype none

interface swm_sample_if;
  logic          valid;
  logic          ready;
  swm_pkg::data_t sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface swm_median_if;
  logic          valid;
  logic          ready;
  swm_pkg::data_t median_value;

  modport source (output valid, output median_value, input ready);
  modport sink   (input valid, input median_value, output ready);
endinterface

`default_nettype wire

// ===== rtl/swm_cell.sv =====
// ----------------------------------------------------------------------------
// swm_cell
// One history slot: holds a sample, counts its rank as the ring passes by.
// ----------------------------------------------------------------------------
`default_nettype none

module swm_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  swm_pkg::swm_cell_ctrl_t ctrl_i,
  input  swm_pkg::idx_t         cell_idx_i,
  input  logic                  active_i,
  input  swm_pkg::data_t        shift_i,
  input  swm_pkg::swm_circ_t    circ_i,
  output swm_pkg::data_t        val_o,
  output swm_pkg::idx_t         rank_o,
  output swm_pkg::swm_circ_t    circ_o
);
  import swm_pkg::*;

  data_t     val_q;
  idx_t      rank_q, rank_d;
  swm_circ_t circ_q, circ_d;
  logic      hit;

  // ties broken by position so every rank is distinct
  assign hit = circ_q.act &&
               ((circ_q.val < val_q) ||
                ((circ_q.val == val_q) && (circ_q.idx < cell_idx_i)));

  always_comb begin
    rank_d = rank_q;
    circ_d = circ_q;
    if (ctrl_i.load) begin
      rank_d = '0;
      circ_d = '{val: shift_i, idx: cell_idx_i, act: active_i};
    end else if (ctrl_i.step) begin
      rank_d = rank_q + IDX_W'(hit);
      circ_d = circ_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= '0;
    end else if (ctrl_i.load) begin
      val_q <= shift_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rank_q <= rank_d;
    circ_q <= circ_d;
  end

  assign val_o  = val_q;
  assign rank_o = rank_q;
  assign circ_o = circ_q;

endmodule

`default_nettype wire

// ===== rtl/swm_select.sv =====
// ----------------------------------------------------------------------------
// swm_select
// Picks the middle pair by rank and forms their floored mean.
// ----------------------------------------------------------------------------
`default_nettype none

module swm_select (
  input  logic                               clk_i,
  input  logic                               capture_i,
  input  swm_pkg::data_t [swm_pkg::WINDOW_MAX-1:0] val_i,
  input  swm_pkg::idx_t  [swm_pkg::WINDOW_MAX-1:0] rank_i,
  input  logic [swm_pkg::WINDOW_MAX-1:0]     active_i,
  input  swm_pkg::len_t                      len_i,
  output swm_pkg::data_t                     median_o
);
  import swm_pkg::*;

  idx_t  k_lo, k_hi;
  data_t lo_d, hi_d, lo_q, hi_q;
  logic signed [DATA_W:0] sum;

  always_comb begin
    k_lo = IDX_W'((len_i - LEN_W'(1)) >> 1);
    k_hi = IDX_W'(len_i >> 1);
    lo_d = '0;
    hi_d = '0;
    for (int i = 0; i < WINDOW_MAX; i++) begin
      if (active_i[i] && (rank_i[i] == k_lo)) lo_d = lo_d | val_i[i];
      if (active_i[i] && (rank_i[i] == k_hi)) hi_d = hi_d | val_i[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (capture_i) begin
      lo_q <= lo_d;
      hi_q <= hi_d;
    end
  end

  assign sum      = (DATA_W+1)'(lo_q) + (DATA_W+1)'(hi_q);
  assign median_o = DATA_W'(sum >>> 1);

endmodule

`default_nettype wire

// ===== rtl/sliding_window_median.sv =====
// ----------------------------------------------------------------------------
// sliding_window_median
// Median over the newest window_length samples of a signed 16-bit stream.
// ----------------------------------------------------------------------------
// Usage:
//   in_if carries one signed sample per request, out_if one median per
//   sample. cfg_we_i/cfg_wdata_i set the window length (reset 5); 0 acts as
//   1 and values above 16 act as 16. Write it only while the block is idle.
//   Each sample shifts into a row of 16 cells that keep the history. A copy
//   of the window then circulates once around the ring, one cell per cycle,
//   and each cell counts how many window samples rank below its own.
//   One sample is worked on at a time: a new sample is taken only once the
//   trip around the ring, the pick of the middle pair and the hand-over
//   to the output register for the last one are through.
//   A finished median waits in the output register; the next sample is still
//   accepted, and its result waits for the register to drain if the
//   receiver stalls.
//   Reset fills the history with zeros, so early medians include them.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_median (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  swm_pkg::len_t      cfg_wdata_i,
  swm_sample_if.sink         in_if,
  swm_median_if.source       out_if
);
  import swm_pkg::*;

  swm_state_e     state_q, state_d;
  len_t           cfg_len_q, n_q, n_cur;
  idx_t           cnt_q, cnt_d;
  logic           out_valid_q;
  data_t          out_data_q;
  logic           accept, out_free;
  swm_cell_ctrl_t cell_ctrl;
  logic           pick;

  data_t     [WINDOW_MAX-1:0] cell_val;
  idx_t      [WINDOW_MAX-1:0] cell_rank;
  swm_circ_t [WINDOW_MAX-1:0] cell_circ;
  logic      [WINDOW_MAX-1:0] load_act, sel_act;
  data_t                      median;

  assign n_cur    = swm_clamp_len(cfg_len_q);
  assign accept   = in_if.valid && in_if.ready;
  assign out_free = !out_valid_q || out_if.ready;

  always_comb begin
    state_d        = state_q;
    cnt_d          = cnt_q;
    in_if.ready    = 1'b0;
    cell_ctrl.load = 1'b0;
    cell_ctrl.step = 1'b0;
    pick           = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_if.ready = 1'b1;
        if (in_if.valid) begin
          cell_ctrl.load = 1'b1;
          cnt_d          = '0;
          state_d        = ST_RANK;
        end
      end
      ST_RANK: begin
        cell_ctrl.step = 1'b1;
        cnt_d          = cnt_q + IDX_W'(1);
        if (cnt_q == IDX_W'(WINDOW_MAX - 1)) state_d = ST_PICK;
      end
      ST_PICK: begin
        pick    = 1'b1;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      cfg_len_q   <= LEN_RESET;
      n_q         <= swm_clamp_len(LEN_RESET);
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (cfg_we_i) cfg_len_q <= cfg_wdata_i;
      if (accept) n_q <= n_cur;
      if ((state_q == ST_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_DONE) && out_free) out_data_q <= median;
  end

  for (genvar g = 0; g < WINDOW_MAX; g++) begin : g_cell
    localparam int unsigned NXT = (g + 1) % WINDOW_MAX;

    assign load_act[g] = swm_active(IDX_W'(g), n_cur);
    assign sel_act[g]  = swm_active(IDX_W'(g), n_q);

    swm_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (cell_ctrl),
      .cell_idx_i (IDX_W'(g)),
      .active_i   (load_act[g]),
      .shift_i    ((g == WINDOW_MAX - 1) ? in_if.sample : cell_val[NXT]),
      .circ_i     (cell_circ[NXT]),
      .val_o      (cell_val[g]),
      .rank_o     (cell_rank[g]),
      .circ_o     (cell_circ[g])
    );
  end

  swm_select u_select (
    .clk_i     (clk_i),
    .capture_i (pick),
    .val_i     (cell_val),
    .rank_i    (cell_rank),
    .active_i  (sel_act),
    .len_i     (n_q),
    .median_o  (median)
  );

  assign out_if.valid        = out_valid_q;
  assign out_if.median_value = out_data_q;

endmodule

`default_nettype wire

// ===== rtl/swm_checker.sv =====
// ----------------------------------------------------------------------------
// swm_checker
// Port-level checks of the median filter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module swm_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_i,
  input logic           out_valid_i,
  input logic           out_ready_i,
  input swm_pkg::data_t median_i
);

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(median_i))
    else $error("stalled median changed");

  // one request in flight: ready drops right after acceptance
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("ready high after accept");

  // still busy picking the median late in the item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |-> ##17 !in_ready_i)
    else $error("ready returned too early");

  // a new median appears only when the input side was busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !$past(in_ready_i))
    else $error("median without work");

endmodule

bind sliding_window_median swm_checker u_swm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_if.valid),
  .in_ready_i  (in_if.ready),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .median_i    (out_if.median_value)
);

`default_nettype wire

// ===== tb/swm_median_checker.sv =====
// ----------------------------------------------------------------------------
// swm_median_checker
// Watches the sample and median channels of the sliding window median filter
// and the length register port, keeps its own copy of the sample history,
// predicts the median of every accepted request and compares it, in order,
// with the medians that leave the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module swm_median_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  swm_pkg::len_t cfg_wdata_i,
  swm_sample_if         smp_mon,
  swm_median_if         med_mon,
  output logic          drained_o,
  output int            fail_count_o,
  output int            checked_count_o
);

  localparam int DEPTH = swm_pkg::WINDOW_MAX;

  swm_pkg::data_t history[DEPTH];
  swm_pkg::len_t  win_len;
  swm_pkg::data_t median_q[$];
  int             n_fail;
  int             n_checked;

  assign fail_count_o    = n_fail;
  assign checked_count_o = n_checked;

  function automatic swm_pkg::data_t window_median(swm_pkg::len_t len);
    int n;
    int k;
    int j;
    int key;
    int sorted[DEPTH];
    n = int'(len);
    if (n < 1) begin
      n = 1;
    end else if (n > DEPTH) begin
      n = DEPTH;
    end
    for (k = 0; k < n; k++) begin
      sorted[k] = int'(history[DEPTH - n + k]);
    end
    for (k = 1; k < n; k++) begin
      key = sorted[k];
      j   = k;
      while (j > 0 && sorted[j - 1] > key) begin
        sorted[j] = sorted[j - 1];
        j--;
      end
      sorted[j] = key;
    end
    if (n % 2 == 1) begin
      return swm_pkg::data_t'(sorted[n / 2]);
    end
    // arithmetic shift gives the floor of the halved sum
    return swm_pkg::data_t'((sorted[n / 2 - 1] + sorted[n / 2]) >>> 1);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    swm_pkg::data_t want;
    if (!rst_ni) begin
      for (int k = 0; k < DEPTH; k++) begin
        history[k] = '0;
      end
      win_len = swm_pkg::LEN_RESET;
      median_q.delete();
      n_fail    = 0;
      n_checked = 0;
      drained_o <= 1'b1;
    end else begin
      if (med_mon.valid && med_mon.ready) begin
        if (median_q.size() == 0) begin
          n_fail++;
          if (n_fail <= 10) begin
            $display("%0t: median %0d arrived with no request pending",
                     $realtime, med_mon.median_value);
          end
        end else begin
          want = median_q.pop_front();
          n_checked++;
          if (med_mon.median_value !== want) begin
            n_fail++;
            if (n_fail <= 10) begin
              $display("%0t: median mismatch, expected %0d, got %0d",
                       $realtime, want, med_mon.median_value);
            end
          end
        end
      end
      if (smp_mon.valid && smp_mon.ready) begin
        for (int k = 1; k < DEPTH; k++) begin
          history[k - 1] = history[k];
        end
        history[DEPTH - 1] = smp_mon.sample;
        median_q.push_back(window_median(win_len));
      end
      if (cfg_we_i) begin
        win_len = cfg_wdata_i;
      end
      drained_o <= (median_q.size() == 0);
    end
  end

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the sliding window median filter. Drives directed and random
// samples through valid/ready channels with random idling on both sides, off in
// the last phase, changes the window length between phases while the block is
// idle, and reports the verdict from the checker's failure count and drain flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam int PHASES       = 10;
  localparam int PHASE_ITEMS  = 145;

  logic          clk_i;
  logic          rst_ni;
  logic          cfg_we_i;
  swm_pkg::len_t cfg_wdata_i;
  logic          idle_en;
  logic          drained;
  int            fail_count;
  int            checked_count;
  int            sent_count;
  int            setting_count;

  swm_sample_if smp_if ();
  swm_median_if med_if ();

  sliding_window_median i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_if       (smp_if),
    .out_if      (med_if)
  );

  swm_median_checker i_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .smp_mon         (smp_if),
    .med_mon         (med_if),
    .drained_o       (drained),
    .fail_count_o    (fail_count),
    .checked_count_o (checked_count)
  );

  initial begin
    clk_i = 1'b0;
  end

  always #2 clk_i = ~clk_i;

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  // receiver side, random stall bursts
  initial begin
    med_if.ready <= 1'b0;
    @(posedge clk_i);
    forever begin
      if (idle_en && $urandom_range(0, 2) == 0) begin
        med_if.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
      end else begin
        med_if.ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk_i);
      end
    end
  end

  task automatic send_sample(swm_pkg::data_t value);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      smp_if.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    smp_if.valid  <= 1'b1;
    smp_if.sample <= value;
    @(posedge clk_i);
    while (!smp_if.ready) @(posedge clk_i);
    sent_count++;
  endtask

  // hold off requests until every median is back, then write the length
  task automatic set_length(swm_pkg::len_t len);
    smp_if.valid <= 1'b0;
    @(posedge clk_i);
    while (!drained) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= len;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    setting_count++;
  endtask

  function automatic swm_pkg::data_t random_sample();
    case ($urandom_range(0, 9))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2, 3:    return swm_pkg::data_t'(int'($urandom_range(0, 8)) - 4);
      4:       return swm_pkg::data_t'(int'($urandom_range(0, 200)) - 100);
      default: return swm_pkg::data_t'($urandom);
    endcase
  endfunction

  initial begin
    swm_pkg::len_t len;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= '0;
    smp_if.valid  <= 1'b0;
    smp_if.sample <= '0;
    idle_en       <= 1'b1;
    sent_count    = 0;
    setting_count = 1;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset length, startup zeros and extremes
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    send_sample(16'sh0000);
    send_sample(-16'sd1);
    send_sample(16'sd1);
    send_sample(16'sh7FFF);
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);

    // zero length acts as one
    set_length(5'd0);
    send_sample(-16'sd5);
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);

    // even length, floor of mixed sign pairs
    set_length(5'd2);
    send_sample(16'sh8000);
    send_sample(16'sh7FFF);
    send_sample(-16'sd1);
    send_sample(16'sd0);
    send_sample(16'sh7FFF);
    send_sample(16'sh7FFF);

    set_length(5'd16);
    send_sample(16'sh8000);
    send_sample(16'sh7FFF);
    send_sample(-16'sd3);
    send_sample(16'sd3);

    // above the window depth saturates
    set_length(5'd17);
    send_sample(16'sh8000);
    send_sample(16'sd7);
    send_sample(16'sh7FFF);

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       len = 5'd31;
        1:       len = 5'd1;
        2:       len = 5'd3;
        3:       len = 5'd4;
        4:       len = 5'd16;
        5:       len = 5'd0;
        default: len = swm_pkg::len_t'($urandom_range(0, 31));
      endcase
      set_length(len);
      if (p == PHASES - 1) begin
        idle_en <= 1'b0;
      end
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        send_sample(random_sample());
      end
    end

    smp_if.valid <= 1'b0;
    @(posedge clk_i);
    while (!drained) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    $display("Summary: %0d samples sent over %0d window length settings",
             sent_count, setting_count);
    $display("Summary: %0d medians compared, %0d failures",
             checked_count, fail_count);
    if (fail_count == 0 && drained) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
